@@ sv/suspend_history_window_tracker_core_macros.svh @@
// ============================================================================
// Suspend history window tracker - assertion macros
// Shared concurrent assertion forms used by the checker. Every property is
// sampled on clk and switched off while rst_n is low.
// ============================================================================
`ifndef SUSPEND_HISTORY_WINDOW_TRACKER_CORE_MACROS_SVH
`define SUSPEND_HISTORY_WINDOW_TRACKER_CORE_MACROS_SVH

// Same-cycle implication.
`define SHWT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SHWT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/shwt_pkg.sv @@
// ============================================================================
// Suspend history window tracker - package
// Word types, command codes and arithmetic helpers shared by all modules.
// ============================================================================
`timescale 1ns / 1ps

package shwt_pkg;

    // Field widths.
    localparam int TIME_W     = 48;
    localparam int TOTAL_W    = TIME_W + 1;
    localparam int ACTION_W   = 2;
    localparam int OUT_CNT_W  = 5;

    // Depth of the command queue between front and back.
    localparam int CMDQ_DEPTH = 2;

    // Action codes on the input word.
    localparam logic [ACTION_W-1:0] ACT_SLEEP = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WAKE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

    // Classified command kinds.
    typedef enum logic [1:0] {
        CMD_SLEEP = 2'd0,
        CMD_WAKE  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_kind_t;

    // Input word.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [TIME_W-1:0]   now_time;
        logic [TIME_W-1:0]   suspend_length;
        logic [TIME_W-1:0]   target_idle;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic                 suspended_flag;
        logic [TIME_W-1:0]    total_suspended;
        logic [OUT_CNT_W-1:0] record_count;
    } out_word_t;

    // Command handed from front to back.
    typedef struct packed {
        cmd_kind_t         kind;
        logic [TIME_W-1:0] now_time;
        logic [TIME_W-1:0] suspend_length;
        logic [TIME_W-1:0] target_idle;
    } cmd_t;

    // One suspend record in the history ring.
    typedef struct packed {
        logic [TIME_W-1:0] wake;
        logic [TIME_W-1:0] slen;
    } rec_t;

    // a - b - c, clamped at zero.
    function automatic logic [TIME_W-1:0] span_clamp(
        input logic [TIME_W-1:0] a,
        input logic [TIME_W-1:0] b,
        input logic [TIME_W-1:0] c
    );
        logic [TIME_W:0] d1;
        logic [TIME_W:0] d2;
        d1 = {1'b0, a} - {1'b0, b};
        d2 = {1'b0, d1[TIME_W-1:0]} - {1'b0, c};
        if (d1[TIME_W] || d2[TIME_W])
        begin
            return '0;
        end
        return d2[TIME_W-1:0];
    endfunction

endpackage

@@ sv/shwt_ram.sv @@
// ============================================================================
// Suspend history window tracker - generic RAM
// One write port and one read port with registered read data.
// ============================================================================
`timescale 1ns / 1ps

module shwt_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/shwt_front.sv @@
// ============================================================================
// Suspend history window tracker - front end
// Accepts input words, decodes the action into a command and holds the
// commands in a short queue for the back end.
// ============================================================================
`timescale 1ns / 1ps

module shwt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  shwt_pkg::in_word_t item,
    output shwt_pkg::cmd_t    cmd,
    output logic              cmd_empty,
    input  logic              cmd_pop
);

    localparam int PTR_W = $clog2(shwt_pkg::CMDQ_DEPTH);
    localparam int CNT_W = $clog2(shwt_pkg::CMDQ_DEPTH + 1);

    shwt_pkg::cmd_t   q_mem [shwt_pkg::CMDQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             do_push;
    logic             do_pop;
    shwt_pkg::cmd_t   decoded;

    // Classify the incoming word.
    always_comb
    begin
        decoded.now_time       = item.now_time;
        decoded.suspend_length = item.suspend_length;
        decoded.target_idle    = item.target_idle;
        unique case (item.action)
            shwt_pkg::ACT_SLEEP: decoded.kind = shwt_pkg::CMD_SLEEP;
            shwt_pkg::ACT_WAKE:  decoded.kind = shwt_pkg::CMD_WAKE;
            shwt_pkg::ACT_QUERY: decoded.kind = shwt_pkg::CMD_QUERY;
            default:             decoded.kind = shwt_pkg::CMD_NOP;
        endcase
    end

    assign full      = (fill_reg == CNT_W'(shwt_pkg::CMDQ_DEPTH));
    assign cmd_empty = (fill_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && !cmd_empty;
    assign cmd       = q_mem[rd_ptr_reg];

    // Queue pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(shwt_pkg::CMDQ_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(shwt_pkg::CMDQ_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= decoded;
        end
    end

endmodule

@@ sv/shwt_back.sv @@
// ============================================================================
// Suspend history window tracker - back end
// Sequencer that carries out one command at a time against the record ring
// and places the result word in an output register.
// ============================================================================
`timescale 1ns / 1ps

module shwt_back #(
    parameter int HISTORY_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  shwt_pkg::cmd_t                cmd,
    input  logic                          cmd_empty,
    output logic                          cmd_pop,
    input  logic                          cfg_wr_en,
    input  logic [shwt_pkg::TIME_W-1:0]   cfg_wr_data,
    output logic                          empty,
    input  logic                          pop,
    output shwt_pkg::out_word_t           result
);

    localparam int IDX_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int TW    = shwt_pkg::TIME_W;
    localparam int TOTW  = shwt_pkg::TOTAL_W;

    typedef enum logic [8:0] {
        ST_IDLE       = 9'b000000001,
        ST_WAKE_SPAN  = 9'b000000010,
        ST_WAKE_ADD   = 9'b000000100,
        ST_TRIM       = 9'b000001000,
        ST_DROP_RD    = 9'b000010000,
        ST_DROP_SPAN  = 9'b000100000,
        ST_DROP_APPLY = 9'b001000000,
        ST_QUERY      = 9'b010000000,
        ST_EMIT       = 9'b100000000
    } state_t;

    // Control state.
    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    newest_reg, newest_next;
    logic [IDX_W-1:0]    oldest_reg, oldest_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TOTW-1:0]     total_reg, total_next;
    logic                asleep_reg, asleep_next;
    logic                init0_reg, init0_next;
    logic [TW-1:0]       max_idle_reg, max_idle_next;
    logic                out_valid_reg, out_valid_next;
    logic                rd_mask_reg, rd_mask_next;

    // Working payload.
    shwt_pkg::cmd_t      cmd_reg, cmd_next;
    logic [TW-1:0]       span_reg, span_next;
    logic [TW-1:0]       wake_o_reg, wake_o_next;
    logic [TW-1:0]       sum_reg, sum_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    left_reg, left_next;
    shwt_pkg::out_word_t out_reg, out_next;

    // Ring memory ports.
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    shwt_pkg::rec_t      ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    shwt_pkg::rec_t      ram_rdata;
    shwt_pkg::rec_t      rec;

    // Helper values.
    logic [IDX_W-1:0]    newest_inc;
    logic [IDX_W-1:0]    oldest_inc;
    logic [IDX_W-1:0]    idx_dec;
    logic                over_limit;
    logic                drop_now;
    logic [TOTW:0]       total_add;
    logic [TW:0]         wake_plus_target;
    logic [TW-1:0]       now_less_sum;
    logic                hit;
    logic [TW:0]         sum_add;
    logic                out_free;

    shwt_ram #(
        .WIDTH($bits(shwt_pkg::rec_t)),
        .DEPTH(HISTORY_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Slot zero holds the reset record until it is first written.
    assign rec = rd_mask_reg ? '0 : ram_rdata;

    // Ring pointer arithmetic.
    assign newest_inc = (newest_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : newest_reg + 1'b1;
    assign oldest_inc = (oldest_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : oldest_reg + 1'b1;
    assign idx_dec    = (idx_reg == '0) ? IDX_W'(HISTORY_DEPTH - 1) : idx_reg - 1'b1;

    // Trim decision: over the window with two or more records, or a full ring.
    assign over_limit = (total_reg > {1'b0, max_idle_reg});
    assign drop_now   = (over_limit && (count_reg >= CNT_W'(2)))
                        || (count_reg >= CNT_W'(HISTORY_DEPTH));

    assign total_add = {1'b0, total_reg} + {{(TOTW + 1 - TW){1'b0}}, span_reg};

    // Query test: wake + target + sum > now, done without wrap.
    assign wake_plus_target = {1'b0, rec.wake} + {1'b0, cmd_reg.target_idle};
    assign now_less_sum     = cmd_reg.now_time - sum_reg;
    assign hit              = (sum_reg > cmd_reg.now_time)
                              || (wake_plus_target > {1'b0, now_less_sum});
    assign sum_add          = {1'b0, sum_reg} + {1'b0, rec.slen};

    assign out_free = !out_valid_reg || pop;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        newest_next    = newest_reg;
        oldest_next    = oldest_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        asleep_next    = asleep_reg;
        init0_next     = init0_reg;
        max_idle_next  = cfg_wr_en ? cfg_wr_data : max_idle_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        span_next      = span_reg;
        wake_o_next    = wake_o_reg;
        sum_next       = sum_reg;
        idx_next       = idx_reg;
        left_next      = left_reg;
        out_next       = out_reg;
        cmd_pop        = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = newest_inc;
        ram_wdata.wake = cmd_reg.now_time;
        ram_wdata.slen = cmd_reg.suspend_length;
        ram_raddr      = newest_reg;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = newest_reg;
                sum_next  = '0;
                idx_next  = newest_reg;
                left_next = count_reg;
                if (!cmd_empty)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    unique case (cmd.kind)
                        shwt_pkg::CMD_SLEEP:
                        begin
                            asleep_next = 1'b1;
                            state_next  = ST_EMIT;
                        end
                        shwt_pkg::CMD_WAKE:  state_next = ST_WAKE_SPAN;
                        shwt_pkg::CMD_QUERY: state_next = ST_QUERY;
                        default:             state_next = ST_EMIT;
                    endcase
                end
            end

            ST_WAKE_SPAN:
            begin
                span_next  = shwt_pkg::span_clamp(cmd_reg.now_time,
                                                  cmd_reg.suspend_length, rec.wake);
                state_next = ST_WAKE_ADD;
            end

            ST_WAKE_ADD:
            begin
                total_next = total_add[TOTW] ? '1 : total_add[TOTW-1:0];
                state_next = ST_TRIM;
            end

            ST_TRIM:
            begin
                ram_raddr = oldest_reg;
                if (drop_now)
                begin
                    state_next = ST_DROP_RD;
                end
                else
                begin
                    // Push the new record and finish the wake-up.
                    ram_we      = 1'b1;
                    newest_next = newest_inc;
                    count_next  = count_reg + 1'b1;
                    asleep_next = 1'b0;
                    if (newest_inc == '0)
                    begin
                        init0_next = 1'b0;
                    end
                    state_next  = ST_EMIT;
                end
            end

            ST_DROP_RD:
            begin
                // Oldest record arrives; fetch the one after it.
                wake_o_next = rec.wake;
                ram_raddr   = oldest_inc;
                state_next  = ST_DROP_SPAN;
            end

            ST_DROP_SPAN:
            begin
                span_next  = shwt_pkg::span_clamp(rec.wake, rec.slen, wake_o_reg);
                state_next = ST_DROP_APPLY;
            end

            ST_DROP_APPLY:
            begin
                total_next  = ({{(TOTW - TW){1'b0}}, span_reg} > total_reg) ?
                              '0 : total_reg - {{(TOTW - TW){1'b0}}, span_reg};
                count_next  = count_reg - 1'b1;
                oldest_next = oldest_inc;
                state_next  = ST_TRIM;
            end

            ST_QUERY:
            begin
                // One record per cycle, newest first.
                ram_raddr = idx_dec;
                idx_next  = idx_dec;
                left_next = left_reg - 1'b1;
                if (hit)
                begin
                    sum_next = sum_add[TW] ? '1 : sum_add[TW-1:0];
                    if (left_reg == CNT_W'(1))
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_next.suspended_flag  = asleep_reg;
                    out_next.total_suspended = sum_reg;
                    out_next.record_count    = shwt_pkg::OUT_CNT_W'(count_reg);
                    out_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rd_mask_next = init0_reg && (ram_raddr == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            newest_reg    <= '0;
            oldest_reg    <= '0;
            count_reg     <= CNT_W'(1);
            total_reg     <= '0;
            asleep_reg    <= 1'b0;
            init0_reg     <= 1'b1;
            max_idle_reg  <= '0;
            out_valid_reg <= 1'b0;
            rd_mask_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            newest_reg    <= newest_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            asleep_reg    <= asleep_next;
            init0_reg     <= init0_next;
            max_idle_reg  <= max_idle_next;
            out_valid_reg <= out_valid_next;
            rd_mask_reg   <= rd_mask_next;
        end
    end

    // Working registers carry no reset.
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        span_reg   <= span_next;
        wake_o_reg <= wake_o_next;
        sum_reg    <= sum_next;
        idx_reg    <= idx_next;
        left_reg   <= left_next;
        out_reg    <= out_next;
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

@@ sv/suspend_history_window_tracker_core.sv @@
// ============================================================================
// Suspend history window tracker - top level
// Keeps a ring of suspend records and answers suspended-time queries.
// ============================================================================
// Words are pushed into a two-entry command queue and carried out one at a
// time by a sequencer that owns the record ring, held in a RAM with one read
// and one write port. A suspend-imminent or unused word goes from idle to
// emit. A suspend-done word takes the span, add, trim and emit states, plus
// a read, span and apply step per dropped record; each drop reads two records
// through the single read port. A query visits at most HISTORY_DEPTH records.
// The result register lets the next word start while a result waits to be
// popped. max_idle_duration may be written only while no word is in flight.
`timescale 1ns / 1ps

module suspend_history_window_tracker_core #(
    parameter int HISTORY_DEPTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  shwt_pkg::in_word_t          item,
    output logic                        empty,
    input  logic                        pop,
    output shwt_pkg::out_word_t         result,
    input  logic                        cfg_wr_en,
    input  logic [shwt_pkg::TIME_W-1:0] cfg_wr_data
);

    shwt_pkg::cmd_t cmd;
    logic           cmd_empty;
    logic           cmd_pop;

    // Front end: accept and classify words.
    shwt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop)
    );

    // Back end: update the ring and produce results.
    shwt_back #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cmd_empty   (cmd_empty),
        .cmd_pop     (cmd_pop),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .empty       (empty),
        .pop         (pop),
        .result      (result)
    );

endmodule

@@ sv/shwt_checker.sv @@
// ============================================================================
// Suspend history window tracker - port checker
// Watches the top level's queue ports and counts words in flight.
// ============================================================================
`timescale 1ns / 1ps
`include "suspend_history_window_tracker_core_macros.svh"

module shwt_checker #(
    parameter int HISTORY_DEPTH = 16
) (
    input logic                clk,
    input logic                rst_n,
    input logic                push,
    input logic                full,
    input logic                pop,
    input logic                empty,
    input shwt_pkg::out_word_t result
);

    // Command queue, the sequencer and the result register.
    localparam int MaxInFlight = shwt_pkg::CMDQ_DEPTH + 2;
    localparam int OutW        = $clog2(MaxInFlight + 2);

    logic [OutW-1:0] inflight_reg;
    logic [OutW-1:0] inflight_next;
    logic            accepted;
    logic            delivered;

    assign accepted  = push && !full;
    assign delivered = pop && !empty;

    // Words accepted and not yet delivered.
    always_comb
    begin
        inflight_next = inflight_reg;
        if (accepted && !delivered)
        begin
            inflight_next = inflight_reg + 1'b1;
        end
        else if (delivered && !accepted)
        begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // A waiting result holds until it is popped.
    `SHWT_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(result), "result changed while stalled")

    // Every result comes from an accepted word.
    `SHWT_ASSERT_IMPL(a_no_spurious, !empty, inflight_reg != '0, "result without accepted word")

    // The block never holds more words than its storage allows.
    `SHWT_ASSERT_IMPL(a_bounded, 1'b1, inflight_reg <= OutW'(MaxInFlight), "too many words in flight")

    // The ring always holds at least one record and never more than its depth.
    `SHWT_ASSERT_IMPL(a_count_range, !empty && (HISTORY_DEPTH < 32), (result.record_count != 0) && (result.record_count <= HISTORY_DEPTH), "record count out of range")

endmodule

bind suspend_history_window_tracker_core shwt_checker #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
) u_shwt_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .pop    (pop),
    .empty  (empty),
    .result (result)
);
